// File: sv/introsort_record_sorter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record sorter
// Concurrent check wrappers for the files that assert.
// ----------------------------------------------------------------------------
`ifndef INTROSORT_RECORD_SORTER_MACROS_SVH
`define INTROSORT_RECORD_SORTER_MACROS_SVH

// Check an implication or condition on every clock edge outside reset.
`define IRS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define IRS_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: sv/irs_pkg.sv
// ----------------------------------------------------------------------------
// Record sorter package
// Record type, command and status bundles, sequencer states and constants.
// ----------------------------------------------------------------------------
package irs_pkg;

  localparam int OFF_W       = 7;   // offsets, counts and addresses
  localparam int DEP_W       = 8;
  localparam int STACK_DEPTH = 6;
  localparam int SP_W        = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam int INS_LIMIT     = 7;   // ranges this small use insertion sort
  localparam int NINTHER_LIMIT = 40;  // above this, pivot is the ninther

  localparam logic [CFG_IDX_W-1:0] CFG_USE_GIVEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEN_DEPTH = 1'd1;

  typedef logic [OFF_W-1:0] off_t;
  typedef logic [DEP_W-1:0] dep_t;

  typedef struct packed {
    logic [31:0] lbd;
    logic [63:0] activity;
    logic [31:0] tag;
  } rec_t;

  typedef struct packed {
    off_t base;
    off_t n;
    dep_t dep;
  } frame_t;

  typedef struct packed {
    logic rd_en;
    off_t ra;
    off_t rb;
    logic we;
    off_t wa;
    logic wsrc_qa;  // 1: write read data A, 0: write read data B
    logic ld;       // write the incoming record
    logic pv_load;  // capture read data A as pivot
  } cmd_t;

  typedef struct packed {
    logic ab_lt;
    logic ab_gt;
    logic ap_lt;
    logic ap_gt;
  } stat_t;

  typedef enum logic [5:0] {
    ST_LOAD, ST_START, ST_TOP, ST_FINISH,
    ST_IS_OUTER, ST_IS_RD, ST_IS_CMP, ST_IS_POST,
    ST_M_RD1, ST_M_RD2, ST_M_RD3, ST_M_FIN,
    ST_PV_RD, ST_PV_LD,
    ST_P_B_CHK, ST_P_B_CMP, ST_P_C_CHK, ST_P_C_CMP, ST_P_BRK,
    ST_BS_CHK, ST_SPLIT,
    ST_H_BLD, ST_H_EXT, ST_H_EXT2,
    ST_S_CHK, ST_S_C1, ST_S_RD2, ST_S_C2,
    ST_SW_RD, ST_SW_W1, ST_SW_W2,
    ST_E_RD, ST_E_SHOW
  } state_t;

  // x sorts before y: smaller lbd, then larger activity
  function automatic logic rec_lt(input rec_t x, input rec_t y);
    return (x.lbd < y.lbd) || ((x.lbd == y.lbd) && (x.activity > y.activity));
  endfunction

endpackage

// File: sv/irs_if.sv
// ----------------------------------------------------------------------------
// Record sorter channels
// Valid/ready channels for incoming and sorted records.
// ----------------------------------------------------------------------------
interface irs_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] lbd;
  logic [63:0] activity;
  logic [31:0] tag;
  logic        last_item;

  modport source (output valid, lbd, activity, tag, last_item, input ready);
  modport sink   (input valid, lbd, activity, tag, last_item, output ready);
endinterface

interface irs_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_lbd;
  logic [63:0] out_activity;
  logic [31:0] out_tag;
  logic        out_last;

  modport source (output valid, out_lbd, out_activity, out_tag, out_last, input ready);
  modport sink   (input valid, out_lbd, out_activity, out_tag, out_last, output ready);
endinterface

// File: sv/irs_datapath.sv
// ----------------------------------------------------------------------------
// Record sorter datapath
// Record store with two registered read ports, pivot register, comparators.
// ----------------------------------------------------------------------------
module irs_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic          clk,
  input  irs_pkg::cmd_t cmd,
  input  irs_pkg::rec_t in_rec,
  output irs_pkg::stat_t st,
  output irs_pkg::rec_t rd_rec
);
  import irs_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  rec_t mem [MAX_ENTRIES];
  rec_t qa;
  rec_t qb;
  rec_t pivot;

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.wa[AW-1:0]] <= cmd.ld ? in_rec : (cmd.wsrc_qa ? qa : qb);
    end
    if (cmd.rd_en) begin
      qa <= mem[cmd.ra[AW-1:0]];
      qb <= mem[cmd.rb[AW-1:0]];
    end
    if (cmd.pv_load) begin
      pivot <= qa;
    end
  end

  always_comb begin
    st.ab_lt = rec_lt(qa, qb);
    st.ab_gt = rec_lt(qb, qa);
    st.ap_lt = rec_lt(qa, pivot);
    st.ap_gt = rec_lt(pivot, qa);
  end

  assign rd_rec = qa;

endmodule

// File: sv/irs_ctrl.sv
// ----------------------------------------------------------------------------
// Record sorter controller
// Sequencer for load, introsort (partition, insertion, heap) and emission.
// ----------------------------------------------------------------------------
`include "introsort_record_sorter_macros.svh"

module irs_ctrl #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_last,
  output logic                               in_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_last,
  input  logic                               cfg_we,
  input  logic [irs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  irs_pkg::stat_t                     st,
  output irs_pkg::cmd_t                      cmd
);
  import irs_pkg::*;

  localparam off_t MAX_N = OFF_W'(MAX_ENTRIES);
  localparam logic [1:0] MID_LO = 2'd0, MID_MI = 2'd1, MID_HI = 2'd2, MID_FINAL = 2'd3;

  state_t state, state_next, ret_st;

  logic   use_gd;
  dep_t   gd;
  off_t   count;
  off_t   base, n;
  dep_t   dep;
  logic [SP_W-1:0] sp;
  frame_t stack [STACK_DEPTH];

  off_t i, j, moves, cap;
  logic abort_f;
  off_t lo, mi, hi, s, mx, my, mz;
  logic [1:0] step;
  logic c1lt, c2lt, c2gt;
  off_t ea, b, c, ed;
  logic moved;
  off_t bi, bk, x0, y0;
  logic bphase;
  off_t sa, sb;
  off_t root, ch, hn, hidx, e;
  logic hphase;
  off_t oi;

  off_t res, left, right, sm_n, sm_b, bg_n, bg_b, k1, k2, ch_c, moves_inc;
  logic sift_more, need_c1;

  function automatic off_t ph(input off_t base_v, input off_t off);
    return base_v + off;
  endfunction

  function automatic dep_t auto_depth(input off_t v);
    logic [2:0] lg;
    lg = '0;
    for (int k = 1; k < OFF_W; k++) begin
      if (v[k]) lg = 3'(k);
    end
    return {4'd0, lg, 1'b0};
  endfunction

  // Median of three from the latched compares and the last one
  always_comb begin
    if (c1lt) res = c2lt ? my : (st.ab_lt ? mz : mx);
    else      res = c2gt ? my : (st.ab_lt ? mx : mz);
  end

  always_comb begin
    left  = b - ea;
    right = ed - c;
    if (left <= right) begin
      sm_n = left;  sm_b = base;
      bg_n = right; bg_b = base + n - right;
    end else begin
      sm_n = right; sm_b = base + n - right;
      bg_n = left;  bg_b = base;
    end
    k1 = (ea < left) ? ea : left;
    k2 = (right < (n - ed - 7'd1)) ? right : (n - ed - 7'd1);
    ch_c = {root[OFF_W-2:0], 1'b1};
    sift_more = root < (hn >> 1);
    need_c1 = (ch_c + 7'd1) < hn;
    moves_inc = moves + 7'd1;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (in_valid && in_last) state_next = ST_START;
      ST_START:    state_next = ST_TOP;
      ST_TOP: begin
        priority if (n <= 7'd1)                      state_next = ST_FINISH;
        else if (dep == '0)                          state_next = ST_H_BLD;
        else if (n <= OFF_W'(INS_LIMIT))             state_next = ST_IS_OUTER;
        else                                         state_next = ST_M_RD1;
      end
      ST_FINISH:   state_next = (sp != '0) ? ST_TOP : ST_E_RD;
      ST_IS_OUTER: state_next = (i >= n) ? ST_FINISH : ST_IS_RD;
      ST_IS_RD:    state_next = ST_IS_CMP;
      ST_IS_CMP:   state_next = st.ab_gt ? ST_SW_W1 : ST_IS_OUTER;
      ST_IS_POST: begin
        priority if (abort_f) state_next = ST_SPLIT;
        else if (j == '0)     state_next = ST_IS_OUTER;
        else                  state_next = ST_IS_RD;
      end
      ST_M_RD1:    state_next = ST_M_RD2;
      ST_M_RD2:    state_next = ST_M_RD3;
      ST_M_RD3:    state_next = ST_M_FIN;
      ST_M_FIN:    state_next = (step == MID_FINAL) ? ST_SW_RD : ST_M_RD1;
      ST_PV_RD:    state_next = ST_PV_LD;
      ST_PV_LD:    state_next = ST_P_B_CHK;
      ST_P_B_CHK:  state_next = (b <= c) ? ST_P_B_CMP : ST_P_BRK;
      ST_P_B_CMP: begin
        priority if (st.ap_gt) state_next = ST_P_C_CHK;
        else if (!st.ap_lt)    state_next = ST_SW_RD;
        else                   state_next = ST_P_B_CHK;
      end
      ST_P_C_CHK:  state_next = (b <= c) ? ST_P_C_CMP : ST_P_BRK;
      ST_P_C_CMP: begin
        priority if (st.ap_lt) state_next = ST_SW_RD;
        else if (!st.ap_gt)    state_next = ST_SW_RD;
        else                   state_next = ST_P_C_CHK;
      end
      ST_P_BRK:    state_next = ST_BS_CHK;
      ST_BS_CHK: begin
        priority if (bi < bk) state_next = ST_SW_RD;
        else if (!bphase)     state_next = ST_BS_CHK;
        else if (!moved)      state_next = ST_IS_OUTER;
        else                  state_next = ST_SPLIT;
      end
      ST_SPLIT:    state_next = (sm_n > 7'd1 || bg_n > 7'd1) ? ST_TOP : ST_FINISH;
      ST_H_BLD:    state_next = (hidx == '0) ? ST_H_EXT : ST_S_CHK;
      ST_H_EXT:    state_next = (e <= 7'd1) ? ST_FINISH : ST_SW_RD;
      ST_H_EXT2:   state_next = ST_S_CHK;
      ST_S_CHK: begin
        priority if (!sift_more) state_next = hphase ? ST_H_EXT : ST_H_BLD;
        else if (need_c1)        state_next = ST_S_C1;
        else                     state_next = ST_S_RD2;
      end
      ST_S_C1:     state_next = ST_S_RD2;
      ST_S_RD2:    state_next = ST_S_C2;
      ST_S_C2: begin
        priority if (st.ab_lt) state_next = ST_SW_W1;
        else if (hphase)       state_next = ST_H_EXT;
        else                   state_next = ST_H_BLD;
      end
      ST_SW_RD:    state_next = ST_SW_W1;
      ST_SW_W1:    state_next = ST_SW_W2;
      ST_SW_W2:    state_next = ret_st;
      ST_E_RD:     state_next = ST_E_SHOW;
      ST_E_SHOW: begin
        if (out_ready) state_next = (oi == count - 7'd1) ? ST_LOAD : ST_E_RD;
      end
      default:     state_next = ST_LOAD;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_ready  = (state == ST_LOAD);
    out_valid = (state == ST_E_SHOW);
    out_last  = (oi == count - 7'd1);
    unique case (state)
      ST_LOAD: begin
        if (in_valid && (count < MAX_N)) begin
          cmd.we = 1'b1; cmd.ld = 1'b1; cmd.wa = count;
        end
      end
      ST_IS_RD: begin
        cmd.rd_en = 1'b1; cmd.ra = ph(base, j - 7'd1); cmd.rb = ph(base, j);
      end
      ST_M_RD1: begin cmd.rd_en = 1'b1; cmd.ra = ph(base, mx); cmd.rb = ph(base, my); end
      ST_M_RD2: begin cmd.rd_en = 1'b1; cmd.ra = ph(base, my); cmd.rb = ph(base, mz); end
      ST_M_RD3: begin cmd.rd_en = 1'b1; cmd.ra = ph(base, mx); cmd.rb = ph(base, mz); end
      ST_PV_RD: begin cmd.rd_en = 1'b1; cmd.ra = base; cmd.rb = base; end
      ST_PV_LD: cmd.pv_load = 1'b1;
      ST_P_B_CHK: begin cmd.rd_en = (b <= c); cmd.ra = ph(base, b); cmd.rb = ph(base, b); end
      ST_P_C_CHK: begin cmd.rd_en = (b <= c); cmd.ra = ph(base, c); cmd.rb = ph(base, c); end
      ST_S_CHK: begin
        cmd.rd_en = sift_more && need_c1;
        cmd.ra = ph(base, ch_c); cmd.rb = ph(base, ch_c + 7'd1);
      end
      ST_S_RD2: begin cmd.rd_en = 1'b1; cmd.ra = ph(base, root); cmd.rb = ph(base, ch); end
      ST_SW_RD: begin cmd.rd_en = 1'b1; cmd.ra = ph(base, sa); cmd.rb = ph(base, sb); end
      ST_SW_W1: begin cmd.we = 1'b1; cmd.wa = ph(base, sa); cmd.wsrc_qa = 1'b0; end
      ST_SW_W2: begin cmd.we = 1'b1; cmd.wa = ph(base, sb); cmd.wsrc_qa = 1'b1; end
      ST_E_RD:  begin cmd.rd_en = 1'b1; cmd.ra = oi; cmd.rb = oi; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      count  <= '0;
      sp     <= '0;
      use_gd <= 1'b0;
      gd     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_USE_GIVEN:   use_gd <= cfg_data[0];
          CFG_GIVEN_DEPTH: gd     <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_LOAD: begin
          if (in_valid && (count < MAX_N)) count <= count + 7'd1;
        end
        ST_START: begin
          base <= '0;
          n    <= count;
          dep  <= use_gd ? gd : auto_depth(count);
          sp   <= '0;
          oi   <= '0;
        end
        ST_TOP: begin
          if (n > 7'd1 && dep != '0) dep <= dep - 8'd1;
          hidx   <= n >> 1;
          hphase <= 1'b0;
          i      <= 7'd1;
          moves  <= '0;
          cap    <= '0;
          lo     <= '0;
          mi     <= n >> 1;
          hi     <= n - 7'd1;
          s      <= n >> 3;
          if (n > OFF_W'(NINTHER_LIMIT)) begin
            step <= MID_LO; mx <= '0; my <= n >> 3; mz <= (n >> 3) << 1;
          end else begin
            step <= MID_FINAL; mx <= '0; my <= n >> 1; mz <= n - 7'd1;
          end
        end
        ST_FINISH: begin
          if (sp != '0) begin
            base <= stack[sp - 3'd1].base;
            n    <= stack[sp - 3'd1].n;
            dep  <= stack[sp - 3'd1].dep;
            sp   <= sp - 3'd1;
          end
        end
        ST_IS_OUTER: j <= i;
        ST_IS_RD: begin sa <= j - 7'd1; sb <= j; end
        ST_IS_CMP: begin
          if (st.ab_gt) begin
            moves   <= moves_inc;
            j       <= j - 7'd1;
            abort_f <= (cap != '0) && (moves_inc > cap);
            ret_st  <= ST_IS_POST;
          end else begin
            i <= i + 7'd1;
          end
        end
        ST_IS_POST: if (!abort_f && j == '0) i <= i + 7'd1;
        ST_M_RD2: c1lt <= st.ab_lt;
        ST_M_RD3: begin c2lt <= st.ab_lt; c2gt <= st.ab_gt; end
        ST_M_FIN: begin
          unique case (step)
            MID_LO: begin
              lo <= res; mx <= mi - s; my <= mi; mz <= mi + s; step <= MID_MI;
            end
            MID_MI: begin
              mi <= res; mx <= hi - (s << 1); my <= hi - s; mz <= hi; step <= MID_HI;
            end
            MID_HI: begin
              hi <= res; mx <= lo; my <= mi; mz <= res; step <= MID_FINAL;
            end
            MID_FINAL: begin
              sa <= '0; sb <= res; ret_st <= ST_PV_RD;
            end
            default: ;
          endcase
        end
        ST_PV_LD: begin
          ea <= 7'd1; b <= 7'd1; c <= n - 7'd1; ed <= n - 7'd1; moved <= 1'b0;
        end
        ST_P_B_CMP: begin
          if (!st.ap_gt) begin
            if (!st.ap_lt) begin
              moved <= 1'b1; sa <= ea; sb <= b; ea <= ea + 7'd1; ret_st <= ST_P_B_CHK;
            end
            b <= b + 7'd1;
          end
        end
        ST_P_C_CMP: begin
          if (st.ap_lt) begin
            moved <= 1'b1; sa <= b; sb <= c;
            b <= b + 7'd1; c <= c - 7'd1; ret_st <= ST_P_B_CHK;
          end else begin
            if (!st.ap_gt) begin
              moved <= 1'b1; sa <= c; sb <= ed; ed <= ed - 7'd1; ret_st <= ST_P_C_CHK;
            end
            c <= c - 7'd1;
          end
        end
        ST_P_BRK: begin
          x0 <= '0; y0 <= b - k1; bk <= k1; bi <= '0; bphase <= 1'b0;
        end
        ST_BS_CHK: begin
          if (bi < bk) begin
            sa <= x0 + bi; sb <= y0 + bi; bi <= bi + 7'd1; ret_st <= ST_BS_CHK;
          end else if (!bphase) begin
            x0 <= b; y0 <= n - k2; bk <= k2; bi <= '0; bphase <= 1'b1;
          end else if (!moved) begin
            i <= 7'd1; moves <= '0; cap <= (n >> 2) + 7'd1; abort_f <= 1'b0;
          end
        end
        ST_SPLIT: begin
          if (sm_n > 7'd1) begin
            if (bg_n > 7'd1) begin
              stack[sp] <= '{base: bg_b, n: bg_n, dep: dep};
              sp <= sp + 3'd1;
            end
            base <= sm_b; n <= sm_n;
          end else if (bg_n > 7'd1) begin
            base <= bg_b; n <= bg_n;
          end
        end
        ST_H_BLD: begin
          if (hidx == '0) begin
            e <= n; hphase <= 1'b1;
          end else begin
            root <= hidx - 7'd1; hn <= n; hidx <= hidx - 7'd1;
          end
        end
        ST_H_EXT: begin sa <= '0; sb <= e - 7'd1; ret_st <= ST_H_EXT2; end
        ST_H_EXT2: begin root <= '0; hn <= e - 7'd1; e <= e - 7'd1; end
        ST_S_CHK: ch <= ch_c;
        ST_S_C1: if (st.ab_lt) ch <= ch + 7'd1;
        ST_S_RD2: begin sa <= root; sb <= ch; end
        ST_S_C2: begin
          if (st.ab_lt) begin root <= ch; ret_st <= ST_S_CHK; end
        end
        ST_E_SHOW: begin
          if (out_ready) begin
            if (oi == count - 7'd1) count <= '0;
            else oi <= oi + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end

  `IRS_ASSERT(a_sp_bound, clk, rst, sp <= SP_W'(STACK_DEPTH), "range stack overflow")
  `IRS_NEVER(a_one_side, clk, rst, in_ready && out_valid, "load and emit overlap")
  `IRS_ASSERT(a_wr_range, clk, rst, cmd.we |-> (cmd.wa < MAX_N), "store write out of range")
  `IRS_ASSERT(a_set_done, clk, rst, (out_valid && out_ready && out_last) |=> (count == '0 && in_ready), "set not closed after final beat")

endmodule

// File: sv/introsort_record_sorter.sv
// ----------------------------------------------------------------------------
// Introsort record sorter
// Collects records, sorts them by ascending lbd and descending activity with
// a three-way partition introsort, then streams them out in order.
// ----------------------------------------------------------------------------
// Loading: one record beat per cycle into the record store.
// Sorting: data dependent; each compare is a registered store read, then a
//   decision, and each exchange is a read of the pair and two writes, the read
//   skipped when the pair was just read, as every move goes through the store's single write port.
// Emission: each beat is a registered store read, then show; the next read waits until the beat is taken.
// Reset: synchronous; clears state, record count, stack pointer and config.
module introsort_record_sorter #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  irs_in_if.sink                         rec_in,
  irs_out_if.source                      rec_out,
  input  logic                           cfg_we,
  input  logic [irs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [irs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import irs_pkg::*;

  cmd_t  cmd;
  stat_t st;
  rec_t  in_rec;
  rec_t  rd_rec;

  // Pack the incoming beat into the store's record layout
  assign in_rec = '{lbd: rec_in.lbd, activity: rec_in.activity, tag: rec_in.tag};

  // Sequencer: owns the handshake, all indexes and the range stack
  irs_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rec_in.valid),
    .in_last   (rec_in.last_item),
    .in_ready  (rec_in.ready),
    .out_valid (rec_out.valid),
    .out_ready (rec_out.ready),
    .out_last  (rec_out.out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .cmd       (cmd)
  );

  // Store and comparators; the read register holds the record on show
  irs_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .in_rec (in_rec),
    .st     (st),
    .rd_rec (rd_rec)
  );

  // Drive the output beat straight from the registered read data
  assign rec_out.out_lbd      = rd_rec.lbd;
  assign rec_out.out_activity = rd_rec.activity;
  assign rec_out.out_tag      = rd_rec.tag;

endmodule

// File: tb/introsort_record_sorter_tb.sv
// ----------------------------------------------------------------------------
// Record sorter testbench
// Streams record sets into the sorter under random input gaps and output
// stalls, predicts the exact sorted order (tie order included) with its own
// introsort, and compares every sorted beat field by field.
// ----------------------------------------------------------------------------
module introsort_record_sorter_tb;
  import irs_pkg::*;

  localparam int MAX_RECS = 64;

  typedef struct {
    rec_t r;
    logic last;
  } sorted_beat_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  irs_in_if  in_ch();
  irs_out_if out_ch();

  introsort_record_sorter #(.MAX_ENTRIES(MAX_RECS)) uut (
    .clk(clk),
    .rst(rst),
    .rec_in(in_ch),
    .rec_out(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: held records, their count and the depth registers.
  rec_t         held[MAX_RECS];
  int           held_count;
  logic         depth_given;
  logic [7:0]   depth_value;
  sorted_beat_t sorted_q[$];

  int  err_count;
  int  beats_checked;
  int  sets_sent;
  int  items_sent;
  bit  calm;        // no idling on either side in the closing stretch
  int  stall_left;

  // Negative when x sorts first: smaller lbd, then larger activity.
  function automatic int rec_order(rec_t x, rec_t y);
    if (x.lbd != y.lbd) return (x.lbd < y.lbd) ? -1 : 1;
    if (x.activity > y.activity) return -1;
    if (x.activity < y.activity) return 1;
    return 0;
  endfunction

  function automatic int held_cmp(int i, int j);
    return rec_order(held[i], held[j]);
  endfunction

  function automatic void held_swap(int i, int j);
    rec_t t;
    t = held[i];
    held[i] = held[j];
    held[j] = t;
  endfunction

  function automatic int median3(int base, int x, int y, int z);
    if (held_cmp(base + x, base + y) < 0)
      return held_cmp(base + y, base + z) < 0 ? y :
             (held_cmp(base + x, base + z) < 0 ? z : x);
    return held_cmp(base + y, base + z) > 0 ? y :
           (held_cmp(base + x, base + z) < 0 ? x : z);
  endfunction

  // Insertion sort; a nonzero cap gives up once more than cap moves are made.
  function automatic bit insert_sort(int base, int n, int cap);
    int moves;
    moves = 0;
    for (int i = 1; i < n; i++) begin
      for (int j = i; j > 0 && held_cmp(base + j - 1, base + j) > 0; j--) begin
        held_swap(base + j, base + j - 1);
        if (cap != 0) begin
          moves++;
          if (moves > cap) return 1'b0;
        end
      end
    end
    return 1'b1;
  endfunction

  function automatic void sift(int base, int root, int n);
    int c;
    while (root < n / 2) begin
      c = 2 * root + 1;
      if (c + 1 < n && held_cmp(base + c, base + c + 1) < 0) c++;
      if (held_cmp(base + root, base + c) >= 0) break;
      held_swap(base + root, base + c);
      root = c;
    end
  endfunction

  function automatic void heap_range(int base, int n);
    for (int i = n / 2; i > 0; i--) sift(base, i - 1, n);
    for (int e = n; e > 1; e--) begin
      held_swap(base, base + e - 1);
      sift(base, 0, e - 1);
    end
  endfunction

  function automatic void block_exchange(int x, int y, int n);
    for (int i = 0; i < n; i++) held_swap(x + i, y + i);
  endfunction

  // Three-way partition introsort over held[base +: n].
  function automatic void sort_range(int base, int n, int dep);
    int lo, mi, hi, s, ea, b, c, ed, k, r, left, right;
    bit moved;
    while (n > 1) begin
      if (dep == 0) begin
        heap_range(base, n);
        return;
      end
      dep--;
      if (n <= INS_LIMIT) begin
        void'(insert_sort(base, n, 0));
        return;
      end
      lo = 0;
      mi = n / 2;
      hi = n - 1;
      if (n > NINTHER_LIMIT) begin
        s = n / 8;
        lo = median3(base, lo, lo + s, lo + 2 * s);
        mi = median3(base, mi - s, mi, mi + s);
        hi = median3(base, hi - 2 * s, hi - s, hi);
      end
      mi = median3(base, lo, mi, hi);
      held_swap(base, base + mi);
      ea = 1;
      b = 1;
      c = n - 1;
      ed = n - 1;
      moved = 1'b0;
      forever begin
        while (b <= c) begin
          r = held_cmp(base + b, base);
          if (r > 0) break;
          if (r == 0) begin
            moved = 1'b1;
            held_swap(base + ea, base + b);
            ea++;
          end
          b++;
        end
        while (b <= c) begin
          r = held_cmp(base + c, base);
          if (r < 0) break;
          if (r == 0) begin
            moved = 1'b1;
            held_swap(base + c, base + ed);
            ed--;
          end
          c--;
        end
        if (b > c) break;
        held_swap(base + b, base + c);
        moved = 1'b1;
        b++;
        c--;
      end
      k = (ea < b - ea) ? ea : b - ea;
      block_exchange(base, base + b - k, k);
      k = (ed - c < n - ed - 1) ? ed - c : n - ed - 1;
      block_exchange(base + b, base + n - k, k);
      if (!moved && insert_sort(base, n, 1 + n / 4)) return;
      left = b - ea;
      right = ed - c;
      if (left <= right) begin
        if (left > 1) sort_range(base, left, dep);
        if (right <= 1) return;
        base += n - right;
        n = right;
      end else begin
        if (right > 1) sort_range(base + n - right, right, dep);
        if (left <= 1) return;
        n = left;
      end
    end
  endfunction

  // Fold one accepted record beat into the predictor.
  function automatic void absorb_record(rec_t r, logic last);
    int n, lg, dep;
    sorted_beat_t sb;
    if (held_count < MAX_RECS) begin
      held[held_count] = r;
      held_count++;
    end
    if (!last) return;
    n = held_count;
    if (depth_given) begin
      dep = depth_value;
    end else begin
      lg = 0;
      for (int k = n; k > 1; k >>= 1) lg++;
      dep = 2 * lg;
    end
    sort_range(0, n, dep);
    for (int i = 0; i < n; i++) begin
      sb.r = held[i];
      sb.last = (i + 1 == n);
      sorted_q.push_back(sb);
    end
    held_count = 0;
    sets_sent++;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t beat %0d: %s", $time, beats_checked, what);
    err_count++;
  endtask

  // Sorted-record sink: check each beat, then pick the next ready value.
  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat lbd=%h tag=%h",
                                  out_ch.out_lbd, out_ch.out_tag));
      end else begin
        want = sorted_q.pop_front();
        if (out_ch.out_lbd !== want.r.lbd)
          report_mismatch($sformatf("lbd %h, want %h", out_ch.out_lbd, want.r.lbd));
        if (out_ch.out_activity !== want.r.activity)
          report_mismatch($sformatf("activity %h, want %h",
                                    out_ch.out_activity, want.r.activity));
        if (out_ch.out_tag !== want.r.tag)
          report_mismatch($sformatf("tag %h, want %h", out_ch.out_tag, want.r.tag));
        if (out_ch.out_last !== want.last)
          report_mismatch($sformatf("last %b, want %b", out_ch.out_last, want.last));
      end
      beats_checked++;
    end
    // Hold ready low for a random burst now and then, never in the calm stretch.
    if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Send one record beat; drop valid afterward only when a gap follows.
  task automatic send_record(rec_t r, logic last);
    bit seen;
    in_ch.valid     <= 1'b1;
    in_ch.lbd       <= r.lbd;
    in_ch.activity  <= r.activity;
    in_ch.tag       <= r.tag;
    in_ch.last_item <= last;
    do begin
      @(negedge clk);
      seen = in_ch.ready;
      @(posedge clk);
    end while (!seen);
    absorb_record(r, last);
    items_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // Make a record. spread 0 means full-range keys; otherwise lbd, and activity
  // mostly too, are squeezed into 0..spread to force many ties.
  function automatic rec_t make_record(int spread);
    rec_t r;
    r.tag = $urandom;
    if (spread == 0) begin
      r.lbd = $urandom;
      r.activity = {$urandom, $urandom};
    end else begin
      r.lbd = $urandom_range(0, spread);
      r.activity = 64'($urandom_range(0, spread));
      if ($urandom_range(0, 3) == 0) r.activity[63 -: 32] = $urandom;
    end
    return r;
  endfunction

  // Send a set of n records. shape: 0 random, 1 ascending, 2 descending,
  // 3 all equal keys.
  task automatic send_set(int n, int spread, int shape);
    rec_t r;
    for (int i = 0; i < n; i++) begin
      r = make_record(spread);
      case (shape)
        1: begin
          r.lbd = 32'(i);
        end
        2: begin
          r.lbd = 32'(n - i);
        end
        3: begin
          r.lbd = 32'd5;
          r.activity = 64'd9;
        end
        default: ;
      endcase
      send_record(r, i == n - 1);
    end
  endtask

  // Drop valid, wait out every sorted beat, then let the sorter settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    in_ch.valid <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx == CFG_USE_GIVEN) depth_given = value[0];
    else depth_value = value;
  endtask

  task automatic set_depth(logic given, logic [7:0] dep);
    drain();
    write_reg(CFG_USE_GIVEN, {7'd0, given});
    write_reg(CFG_GIVEN_DEPTH, dep);
    cfg_we <= 1'b0;
  endtask

  // Single record, field extremes, ties and small ordered sets.
  task automatic test_directed;
    rec_t r;
    set_depth(1'b0, 8'd0);
    r = '{lbd: 32'hFFFF_FFFF, activity: 64'hFFFF_FFFF_FFFF_FFFF, tag: 32'hFFFF_FFFF};
    send_record(r, 1'b1);
    r = '{lbd: 32'hFFFF_FFFF, activity: 64'd0, tag: 32'h0};
    send_record(r, 1'b0);
    r = '{lbd: 32'd0, activity: 64'hFFFF_FFFF_FFFF_FFFF, tag: 32'h1};
    send_record(r, 1'b0);
    r = '{lbd: 32'd0, activity: 64'h8000_0000_0000_0000, tag: 32'h2};
    send_record(r, 1'b0);
    r = '{lbd: 32'd0, activity: 64'd1, tag: 32'hA5A5_5A5A};
    send_record(r, 1'b1);
    send_set(8, 0, 3);   // equal keys: tie order comes from the partition
    send_set(8, 0, 2);   // reverse order just above the insertion limit
  endtask

  // Walk the depth registers through their extremes and a few middle values.
  task automatic test_depth_settings;
    logic [7:0] deps[5] = '{8'd0, 8'd1, 8'd3, 8'd255, 8'hAA};
    foreach (deps[i]) begin
      set_depth(1'b1, deps[i]);
      send_set($urandom_range(8, 20), 3, 0);
      send_set($urandom_range(2, 7), 0, 0);
      if (i % 2 == 0) send_set($urandom_range(41, 50), 0, 0);
    end
    set_depth(1'b1, 8'h55);
    send_set(16, 2, 0);
    set_depth(1'b0, 8'd0);
  endtask

  // Overfill the store: extra records are dropped, the held set still sorts.
  task automatic test_store_full;
    for (int i = 0; i < MAX_RECS + 2; i++)
      send_record(make_record(i < 20 ? 4 : 0), i == MAX_RECS + 1);
  endtask

  // Random sets, mostly small, with ties, presorted runs and a few large sets.
  task automatic test_random_sets;
    int n, pick;
    while (items_sent < 345) begin
      pick = $urandom_range(0, 9);
      n = (pick == 0) ? $urandom_range(41, MAX_RECS) : $urandom_range(1, 18);
      send_set(n, pick < 4 ? 0 : $urandom_range(1, 6), pick == 9 ? $urandom_range(1, 3) : 0);
    end
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_calm;
    drain();
    calm = 1'b1;
    for (int i = 0; i < 4; i++) send_set($urandom_range(5, 14), 3, 0);
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.lbd = '0;
    in_ch.activity = '0;
    in_ch.tag = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready = 1'b0;
    held_count = 0;
    depth_given = 1'b0;
    depth_value = '0;
    err_count = 0;
    beats_checked = 0;
    sets_sent = 0;
    items_sent = 0;
    calm = 1'b0;
    stall_left = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_depth_settings();
    test_store_full();
    test_random_sets();
    test_calm();

    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d record beats in %0d sets, %0d sorted beats checked,",
             items_sent, sets_sent, beats_checked);
    $display("over automatic and given depth budgets including zero and 255.");
    if (err_count == 0 && sorted_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Timeout with %0d sorted beats outstanding", sorted_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
